[src/aabb_pkg.sv]
package aabb_pkg;

   localparam int COORD_BITS  = 32;
   localparam int COEF_BITS   = 16;
   localparam int COEF_FRAC   = COEF_BITS - 4;
   localparam int PROD_BITS   = COORD_BITS + COEF_BITS;
   localparam int SCALED_BITS = PROD_BITS - COEF_FRAC;
   localparam int SUM_BITS    = SCALED_BITS + 2;
   localparam int AXES        = 3;
   localparam int ROW_BITS    = AXES * COEF_BITS;
   localparam int REQ_BITS    = AXES * ROW_BITS + 3 * AXES * COORD_BITS;
   localparam int REQ_BYTES   = (REQ_BITS + 7) / 8;
   localparam int RSP_BITS    = 2 * AXES * COORD_BITS;
   localparam int RSP_BYTES   = (RSP_BITS + 7) / 8;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [ROW_BITS-1:0]          coef_row_type;
   typedef coord_type                    coord_vec_type [AXES];

   function automatic coord_type saturate_coord(input logic signed [SUM_BITS-1:0] v);
      logic [SUM_BITS-COORD_BITS:0] top;
      coord_type                    result;
      top = v[SUM_BITS-1:COORD_BITS-1];
      if ((top == '0) || (top == '1)) begin
         result = v[COORD_BITS-1:0];
      end else if (v[SUM_BITS-1]) begin
         result = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         result = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
      return result;
   endfunction

endpackage

[src/aabb_row.sv]
module aabb_row
   import aabb_pkg::*;
(
   input  logic          clock,
   input  logic          enable,
   input  coef_row_type  row,
   input  coord_type     shift,
   input  coord_vec_type local_min,
   input  coord_vec_type local_max,
   output coord_type     world_min,
   output coord_type     world_max
);

   logic signed [SCALED_BITS-1:0] p_ff [AXES];
   logic signed [SCALED_BITS-1:0] q_ff [AXES];
   logic signed [SCALED_BITS-1:0] p_in [AXES];
   logic signed [SCALED_BITS-1:0] q_in [AXES];
   coord_type                     shift_ff;

   // products truncated toward minus infinity
   always_comb begin
      for (int c = 0; c < AXES; c++) begin
         logic signed [COEF_BITS-1:0] k;
         logic signed [PROD_BITS-1:0] pa;
         logic signed [PROD_BITS-1:0] pb;
         k = row[c*COEF_BITS +: COEF_BITS];
         pa = PROD_BITS'(local_min[c]) * PROD_BITS'(k);
         pb = PROD_BITS'(local_max[c]) * PROD_BITS'(k);
         p_in[c] = pa[PROD_BITS-1:COEF_FRAC];
         q_in[c] = pb[PROD_BITS-1:COEF_FRAC];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p_ff     <= p_in;
         q_ff     <= q_in;
         shift_ff <= shift;
      end
   end

   always_comb begin
      logic signed [SUM_BITS-1:0] lo;
      logic signed [SUM_BITS-1:0] hi;
      lo = SUM_BITS'(shift_ff);
      hi = SUM_BITS'(shift_ff);
      for (int c = 0; c < AXES; c++) begin
         if (p_ff[c] <= q_ff[c]) begin
            lo = lo + SUM_BITS'(p_ff[c]);
            hi = hi + SUM_BITS'(q_ff[c]);
         end else begin
            lo = lo + SUM_BITS'(q_ff[c]);
            hi = hi + SUM_BITS'(p_ff[c]);
         end
      end
      world_min = saturate_coord(lo);
      world_max = saturate_coord(hi);
   end

endmodule

[src/aabb_affine_transform.sv]
// World-space bounding box of a local box under an affine transform. One item
// is taken per cycle while no stage is stalled, and its result passes through
// an input register, a register after the eighteen coefficient-by-corner
// multipliers, and the result register behind the min/max select, the
// four-term sum and saturation. Each stage holds under backpressure and a
// bubble in any stage is filled, so throughput is one item per cycle while
// rsp_tready stays high. Coordinates are signed Q16.16, coefficients Q4.12.
module aabb_affine_transform
   import aabb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // linear_row0, linear_row1, linear_row2, shift_x, shift_y, shift_z,
   // local_min_x, local_min_y, local_min_z, local_max_x, local_max_y, local_max_z
   input  logic [REQ_BYTES*8-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // world_min_x, world_min_y, world_min_z, world_max_x, world_max_y, world_max_z
   output logic [RSP_BYTES*8-1:0] rsp_tdata
);

   localparam int SHIFT_BASE = AXES * ROW_BITS;
   localparam int MIN_BASE   = SHIFT_BASE + AXES * COORD_BITS;
   localparam int MAX_BASE   = MIN_BASE + AXES * COORD_BITS;

   logic                 v1_ff, v2_ff, v3_ff;
   logic                 en1, en2, en3;
   logic [REQ_BITS-1:0]  req_ff;
   logic [RSP_BITS-1:0]  rsp_ff;
   logic [RSP_BITS-1:0]  rsp_in;
   coord_vec_type        local_min;
   coord_vec_type        local_max;
   coord_type            world_min [AXES];
   coord_type            world_max [AXES];

   assign en3 = !v3_ff || rsp_tready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_tvalid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && req_tvalid) begin
         req_ff <= req_tdata[REQ_BITS-1:0];
      end
      if (en3 && v2_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      for (int c = 0; c < AXES; c++) begin
         local_min[c] = req_ff[MIN_BASE + c*COORD_BITS +: COORD_BITS];
         local_max[c] = req_ff[MAX_BASE + c*COORD_BITS +: COORD_BITS];
      end
   end

   for (genvar r = 0; r < AXES; r++) begin : g_row
      aabb_row u_row (
         .clock     (clock),
         .enable    (en2 && v1_ff),
         .row       (req_ff[r*ROW_BITS +: ROW_BITS]),
         .shift     (req_ff[SHIFT_BASE + r*COORD_BITS +: COORD_BITS]),
         .local_min (local_min),
         .local_max (local_max),
         .world_min (world_min[r]),
         .world_max (world_max[r])
      );
      assign rsp_in[r*COORD_BITS +: COORD_BITS]          = world_min[r];
      assign rsp_in[(AXES+r)*COORD_BITS +: COORD_BITS]   = world_max[r];
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = (RSP_BYTES*8)'(rsp_ff);

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ($signed(rsp_ff[0 +: COORD_BITS]) <= $signed(rsp_ff[3*COORD_BITS +: COORD_BITS])) &&
         ($signed(rsp_ff[COORD_BITS +: COORD_BITS]) <=
          $signed(rsp_ff[4*COORD_BITS +: COORD_BITS])) &&
         ($signed(rsp_ff[2*COORD_BITS +: COORD_BITS]) <=
          $signed(rsp_ff[5*COORD_BITS +: COORD_BITS])))
      else $error("world box min exceeds max");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v1_ff)
      else $error("accepted item lost from input stage");

   a_mid_holds: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !en3) |=> v2_ff)
      else $error("product stage dropped a stalled item");

   a_no_full_accept: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && !rsp_tready) |-> !req_tready)
      else $error("item accepted with full pipeline");

endmodule

[verif/aabb_checker.sv]
`timescale 1ns / 1ps

module aabb_checker
   import aabb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_BYTES*8-1:0] req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_BYTES*8-1:0] rsp_tdata,
   output int                     mismatches,
   output int                     outstanding
);

   localparam longint COORD_TOP = (longint'(1) << (COORD_BITS - 1)) - 1;
   localparam longint COORD_BOT = -COORD_TOP - 1;

   logic [RSP_BYTES*8-1:0] world_box_q [$];
   int                     error_count = 0;
   int                     in_flight = 0;
   string                  field_name [2*AXES] = '{"world_min_x", "world_min_y", "world_min_z",
                                                   "world_max_x", "world_max_y", "world_max_z"};

   assign mismatches  = error_count;
   assign outstanding = in_flight;

   function automatic logic [RSP_BYTES*8-1:0] world_box(input logic [REQ_BYTES*8-1:0] item);
      coef_row_type                rows  [AXES];
      coord_type                   org   [AXES];
      coord_type                   lo_c  [AXES];
      coord_type                   hi_c  [AXES];
      logic signed [COEF_BITS-1:0] k;
      longint                      p, q, lo_sum, hi_sum;
      coord_type                   lo_sat, hi_sat;
      logic [RSP_BYTES*8-1:0]      box;
      box = '0;
      for (int a = 0; a < AXES; a++) begin
         rows[a] = item[a*ROW_BITS +: ROW_BITS];
         org[a]  = item[AXES*ROW_BITS + a*COORD_BITS +: COORD_BITS];
         lo_c[a] = item[AXES*ROW_BITS + (AXES + a)*COORD_BITS +: COORD_BITS];
         hi_c[a] = item[AXES*ROW_BITS + (2*AXES + a)*COORD_BITS +: COORD_BITS];
      end
      for (int r = 0; r < AXES; r++) begin
         lo_sum = longint'(org[r]);
         hi_sum = longint'(org[r]);
         for (int c = 0; c < AXES; c++) begin
            k = rows[r][c*COEF_BITS +: COEF_BITS];
            // floor of the scaled product
            p = (longint'(lo_c[c]) * longint'(k)) >>> COEF_FRAC;
            q = (longint'(hi_c[c]) * longint'(k)) >>> COEF_FRAC;
            if (p <= q) begin
               lo_sum += p;
               hi_sum += q;
            end else begin
               lo_sum += q;
               hi_sum += p;
            end
         end
         if (lo_sum > COORD_TOP) lo_sum = COORD_TOP;
         if (lo_sum < COORD_BOT) lo_sum = COORD_BOT;
         if (hi_sum > COORD_TOP) hi_sum = COORD_TOP;
         if (hi_sum < COORD_BOT) hi_sum = COORD_BOT;
         lo_sat = lo_sum[COORD_BITS-1:0];
         hi_sat = hi_sum[COORD_BITS-1:0];
         box[r*COORD_BITS +: COORD_BITS]          = lo_sat;
         box[(AXES + r)*COORD_BITS +: COORD_BITS] = hi_sat;
      end
      return box;
   endfunction

   always @(posedge clock) begin : watch
      logic [RSP_BYTES*8-1:0] want;
      coord_type              want_field, got_field;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (world_box_q.size() == 0) begin
               $error("result item with no expected result: %h", rsp_tdata);
               error_count++;
            end else begin
               want = world_box_q.pop_front();
               for (int f = 0; f < 2*AXES; f++) begin
                  want_field = want[f*COORD_BITS +: COORD_BITS];
                  got_field  = rsp_tdata[f*COORD_BITS +: COORD_BITS];
                  if (want_field !== got_field) begin
                     $error("%s expected %0d got %0d", field_name[f], want_field, got_field);
                     error_count++;
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            world_box_q.insert(world_box_q.size(), world_box(req_tdata));
         end
      end
      in_flight <= world_box_q.size();
   end

endmodule

[verif/tb_aabb_affine_transform.sv]
`timescale 1ns / 1ps

module tb_aabb_affine_transform;
   import aabb_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_BYTES*8-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_BYTES*8-1:0] rsp_tdata;
   int                     mismatches;
   int                     outstanding;
   bit                     calm = 1'b0;
   bit                     hold_request = 1'b0;

   aabb_affine_transform dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   aabb_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      forever begin
         #6 clock = ~clock;
      end
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin : receiver
      int held;
      forever begin
         @(posedge clock);
         if (hold_request && !reset) begin
            hold_request = 1'b0;
            for (held = 0; held < 250; held++) begin
               rsp_tready <= 1'b0;
               @(posedge clock);
            end
         end
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 8);
         end
      end
   end

   task automatic send_box(input coef_row_type r0, r1, r2,
                           input coord_type sx, sy, sz,
                           input coord_type nx, ny, nz,
                           input coord_type xx, xy, xz);
      logic [REQ_BYTES*8-1:0] item;
      item = '0;
      item[REQ_BITS-1:0] = {xz, xy, xx, nz, ny, nx, sz, sy, sx, r2, r1, r0};
      if (!calm) begin
         while ($urandom_range(99) < 8) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= item;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic coord_type extreme_coord();
      coord_type v;
      case ($urandom_range(4))
         0:       v = 32'h8000_0000;
         1:       v = 32'h7FFF_FFFF;
         2:       v = 32'h0000_0000;
         3:       v = 32'hFFFF_FFFF;
         default: v = 32'h0001_0000;
      endcase
      return v;
   endfunction

   task automatic send_random_box();
      coef_row_type                rows [AXES];
      coord_type                   org  [AXES];
      coord_type                   lo_c [AXES];
      coord_type                   hi_c [AXES];
      coord_type                   mid, span, tmp;
      logic signed [COEF_BITS-1:0] k;
      int                          mode;
      mode = $urandom_range(9);
      for (int a = 0; a < AXES; a++) begin
         if (mode == 6 || mode == 7) begin
            // raw bits
            rows[a] = ROW_BITS'({$urandom, $urandom});
            org[a]  = $urandom;
            lo_c[a] = $urandom;
            hi_c[a] = $urandom;
         end else if (mode == 8) begin
            for (int c = 0; c < AXES; c++) begin
               case ($urandom_range(4))
                  0:       k = 16'h8000;
                  1:       k = 16'h7FFF;
                  2:       k = 16'h0000;
                  3:       k = 16'hFFFF;
                  default: k = 16'h1000;
               endcase
               rows[a][c*COEF_BITS +: COEF_BITS] = k;
            end
            org[a]  = extreme_coord();
            lo_c[a] = extreme_coord();
            hi_c[a] = extreme_coord();
         end else begin
            // plausible transform and ordered box, swapped corners in mode 9
            for (int c = 0; c < AXES; c++) begin
               k = COEF_BITS'($urandom_range(32'h4000) - 32'h2000);
               rows[a][c*COEF_BITS +: COEF_BITS] = k;
            end
            org[a]  = $urandom_range(32'h2000_0000) - 32'h1000_0000;
            mid     = $urandom_range(32'h0200_0000) - 32'h0100_0000;
            span    = $urandom_range(32'h0010_0000);
            lo_c[a] = mid - span;
            hi_c[a] = mid + span;
            if (mode == 9) begin
               tmp     = lo_c[a];
               lo_c[a] = hi_c[a];
               hi_c[a] = tmp;
            end
         end
      end
      send_box(rows[0], rows[1], rows[2], org[0], org[1], org[2],
               lo_c[0], lo_c[1], lo_c[2], hi_c[0], hi_c[1], hi_c[2]);
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero and identity
      send_box('0, '0, '0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_box(48'h0000_0000_1000, 48'h0000_1000_0000, 48'h1000_0000_0000, 0, 0, 0,
               32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
               32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_box(48'h0000_0000_1000, 48'h0000_1000_0000, 48'h1000_0000_0000,
               32'h0005_8000, 32'hFFFD_0000, 0,
               32'hFFFE_0000, 32'hFFFF_0000, 0,
               32'h0003_0000, 32'h0004_0000, 32'h0001_0000);
      // rotation about z
      send_box(48'h0000_0B50_0B50, 48'h0000_0B50_F4B0, 48'h1000_0000_0000, 0, 0, 0,
               32'hFFF6_0000, 32'hFFEC_0000, 32'hFFE2_0000,
               32'h000A_0000, 32'h0014_0000, 32'h001E_0000);
      // swapped corners
      send_box(48'hF000_1000_F000, 48'h1000_F000_1000, 48'hF000_F000_1000,
               32'h0001_0000, 0, 32'hFFFF_0000,
               32'h0005_0000, 32'h0005_0000, 32'h0005_0000,
               32'hFFFD_0000, 32'hFFFD_0000, 32'hFFFD_0000);
      // coefficient and coordinate extremes, saturation both ways
      send_box(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 0, 0, 0,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_box(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
               32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      // translation only
      send_box('0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678,
               32'h7FFF_FFFF, 32'h8000_0000, 32'h8765_4321);
      // truncation toward minus infinity
      send_box(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0, 0, 0,
               32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
               32'h0000_0FFF, 32'h0000_1000, 32'h0000_1001);
      send_box(48'h0001_0001_0001, 48'h0001_0001_0001, 48'h0001_0001_0001, 0, 0, 0,
               32'hFFFF_FFFF, 32'hFFFF_F001, 32'hFFFF_F000,
               32'h0000_0FFF, 32'h0000_1000, 32'h0000_2FFF);
      // overflow through the sum
      send_box(48'h0000_0000_1000, 48'h0000_1000_0000, 48'h1000_0000_0000,
               32'h7FFF_0000, 32'h8000_0000, 32'h4000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h4000_0000,
               32'h7FFF_FFFF, 32'h0000_0000, 32'h4000_0000);
      send_box(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_box(48'hAAAA_5555_AAAA, 48'h5555_AAAA_5555, 48'hAAAA_5555_AAAA,
               32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
               32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
               32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      send_box(48'h5555_AAAA_5555, 48'hAAAA_5555_AAAA, 48'h5555_AAAA_5555,
               32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
               32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
               32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);

      for (int n = 0; n < 1836; n++) begin
         calm = (n >= 700 && n < 1000);
         if (n == 300) begin
            hold_request = 1'b1;
         end
         if (n == 1300) begin
            // drain before going on
            req_tvalid <= 1'b0;
            do @(posedge clock); while (outstanding != 0);
         end
         send_random_box();
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[files.f]
src/aabb_pkg.sv
src/aabb_row.sv
src/aabb_affine_transform.sv
verif/aabb_checker.sv
verif/tb_aabb_affine_transform.sv
